@@ rtl/core/swd_pkg.sv @@
// Shared types, codes and helper functions for the SWD host transaction engine.
// Used by swd_step, swd_host_transaction_engine and swd_checker; no dependencies.

package swd_pkg;

   // Default count of high clocks in a line reset.
   localparam int LINE_RESET_HIGH_CLOCKS_DEFAULT = 50;

   // Reset value of the attempt limit register.
   localparam logic [7:0] MAX_ATTEMPTS_RESET = 8'd100;

   // Bit counts of the transaction fields.
   localparam logic [5:0] REQ_BITS  = 6'd8;
   localparam logic [5:0] ACK_BITS  = 6'd3;
   localparam logic [5:0] DATA_BITS = 6'd32;

   // Largest attempt count the counter holds.
   localparam logic [7:0] ATTEMPTS_SAT = 8'd255;

   // Action codes of an input beat.
   localparam logic [1:0] ACT_READ       = 2'd0;
   localparam logic [1:0] ACT_WRITE      = 2'd1;
   localparam logic [1:0] ACT_LINE_RESET = 2'd2;
   localparam logic [1:0] ACT_TICK       = 2'd3;

   // Target acknowledge codes, as received LSB first.
   localparam logic [2:0] ACK_OK    = 3'b001;
   localparam logic [2:0] ACK_WAIT  = 3'b010;
   localparam logic [2:0] ACK_FAULT = 3'b100;

   // Transaction status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FAULT      = 3'd1;
   localparam logic [2:0] ST_WAIT_LIMIT = 3'd2;
   localparam logic [2:0] ST_BAD_ACK    = 3'd3;
   localparam logic [2:0] ST_PARITY_ERR = 3'd4;

   // Sequencer phase codes.
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_LRESET    = 4'd1;
   localparam logic [3:0] PH_REQ       = 4'd2;
   localparam logic [3:0] PH_TRN_ACK   = 4'd3;
   localparam logic [3:0] PH_ACK       = 4'd4;
   localparam logic [3:0] PH_RDATA     = 4'd5;
   localparam logic [3:0] PH_RPAR      = 4'd6;
   localparam logic [3:0] PH_TRN_W     = 4'd7;
   localparam logic [3:0] PH_WDATA     = 4'd8;
   localparam logic [3:0] PH_WPAR      = 4'd9;
   localparam logic [3:0] PH_TRN_RETRY = 4'd10;
   localparam logic [3:0] PH_TRN_END   = 4'd11;

   // Input beat.
   typedef struct packed {
      logic [1:0]  action;
      logic        port_is_ap;
      logic [1:0]  reg_addr;
      logic [31:0] write_data;
      logic        swdio_in;
   } swd_req_type;

   // Result beat.
   typedef struct packed {
      logic        swdio_out;
      logic        swdio_drive;
      logic        clock_pulse;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] read_data;
   } swd_rsp_type;

   // Sequencer state carried from one beat to the next.
   typedef struct packed {
      logic [3:0]  phase;
      logic [5:0]  bit_count;
      logic [7:0]  request_header;
      logic [31:0] data_shift;
      logic [2:0]  ack_shift;
      logic        parity_acc;
      logic [7:0]  attempts_used;
      logic        is_write;
      logic [31:0] read_word;
      logic [2:0]  final_status;
   } swd_state_type;

   // Build the 8-bit request header: start, APnDP, RnW, A[3:2], parity, stop, park.
   function automatic logic [7:0] make_header(logic ap, logic rnw, logic [1:0] addr);
      logic par;
      par = ap ^ rnw ^ addr[0] ^ addr[1];
      return {1'b1, 1'b0, par, addr, rnw, ap, 1'b1};
   endfunction

endpackage

@@ rtl/core/swd_step.sv @@
// Next-state and result logic of the SWD sequencer for one input beat.
// Depends on swd_pkg for the beat, state types and the phase codes.

module swd_step #(
   parameter int LINE_RESET_HIGH_CLOCKS = swd_pkg::LINE_RESET_HIGH_CLOCKS_DEFAULT
) (
   input  swd_pkg::swd_state_type state_cur,
   input  swd_pkg::swd_req_type   req,
   input  logic [7:0]             max_attempts,
   output swd_pkg::swd_state_type state_nxt,
   output swd_pkg::swd_rsp_type   rsp
);
   import swd_pkg::*;

   localparam logic [5:0] LrHigh = 6'(LINE_RESET_HIGH_CLOCKS);

   logic [7:0] limit;
   logic [5:0] bc_inc;
   logic [2:0] ack_acc;
   logic       start_write;
   logic       o_out;
   logic       o_drive;
   logic       o_clk;
   logic       o_done;

   // Shared helpers for the phase logic.
   assign limit       = (max_attempts == 8'd0) ? 8'd1 : max_attempts;
   assign bc_inc      = state_cur.bit_count + 6'd1;
   assign ack_acc     = state_cur.ack_shift | (3'(req.swdio_in) << state_cur.bit_count[1:0]);
   assign start_write = (req.action == ACT_WRITE);

   // Sequencer step: start beats latch a job while idle, tick beats clock one bit.
   always_comb begin
      state_nxt = state_cur;
      o_out     = 1'b0;
      o_drive   = 1'b1;
      o_clk     = 1'b0;
      o_done    = 1'b0;
      if (req.action != ACT_TICK) begin
         if (state_cur.phase == PH_IDLE) begin
            state_nxt.final_status = ST_OK;
            state_nxt.bit_count    = '0;
            if (req.action == ACT_LINE_RESET) begin
               state_nxt.phase = PH_LRESET;
            end else begin
               state_nxt.is_write       = start_write;
               state_nxt.request_header = make_header(req.port_is_ap, ~start_write,
                                                      req.reg_addr);
               state_nxt.data_shift     = req.write_data;
               state_nxt.attempts_used  = 8'd1;
               state_nxt.phase          = PH_REQ;
            end
         end
      end else begin
         o_clk = 1'b1;
         case (state_cur.phase)
            PH_LRESET: begin
               if (state_cur.bit_count < LrHigh) begin
                  o_out               = 1'b1;
                  state_nxt.bit_count = bc_inc;
               end else begin
                  state_nxt.bit_count    = '0;
                  state_nxt.final_status = ST_OK;
                  state_nxt.phase        = PH_IDLE;
                  o_done                 = 1'b1;
               end
            end
            PH_REQ: begin
               o_out = state_cur.request_header[state_cur.bit_count[2:0]];
               if (bc_inc >= REQ_BITS) begin
                  state_nxt.bit_count = '0;
                  state_nxt.phase     = PH_TRN_ACK;
               end else begin
                  state_nxt.bit_count = bc_inc;
               end
            end
            PH_TRN_ACK: begin
               o_drive             = 1'b0;
               state_nxt.ack_shift = '0;
               state_nxt.bit_count = '0;
               state_nxt.phase     = PH_ACK;
            end
            PH_ACK: begin
               o_drive             = 1'b0;
               state_nxt.ack_shift = ack_acc;
               if (bc_inc >= ACK_BITS) begin
                  state_nxt.bit_count = '0;
                  if (ack_acc == ACK_OK) begin
                     if (state_cur.is_write) begin
                        state_nxt.phase = PH_TRN_W;
                     end else begin
                        state_nxt.data_shift = '0;
                        state_nxt.parity_acc = 1'b0;
                        state_nxt.phase      = PH_RDATA;
                     end
                  end else if (ack_acc == ACK_WAIT) begin
                     if (state_cur.attempts_used < limit) begin
                        state_nxt.phase = PH_TRN_RETRY;
                     end else begin
                        state_nxt.final_status = ST_WAIT_LIMIT;
                        state_nxt.phase        = PH_TRN_END;
                     end
                  end else if (ack_acc == ACK_FAULT) begin
                     state_nxt.final_status = ST_FAULT;
                     state_nxt.phase        = PH_TRN_END;
                  end else begin
                     state_nxt.final_status = ST_BAD_ACK;
                     state_nxt.phase        = PH_TRN_END;
                  end
               end else begin
                  state_nxt.bit_count = bc_inc;
               end
            end
            PH_RDATA: begin
               o_drive              = 1'b0;
               state_nxt.data_shift = {req.swdio_in, state_cur.data_shift[31:1]};
               state_nxt.parity_acc = state_cur.parity_acc ^ req.swdio_in;
               if (bc_inc >= DATA_BITS) begin
                  state_nxt.bit_count = '0;
                  state_nxt.phase     = PH_RPAR;
               end else begin
                  state_nxt.bit_count = bc_inc;
               end
            end
            PH_RPAR: begin
               o_drive = 1'b0;
               if (req.swdio_in == state_cur.parity_acc) begin
                  state_nxt.read_word    = state_cur.data_shift;
                  state_nxt.final_status = ST_OK;
               end else begin
                  state_nxt.final_status = ST_PARITY_ERR;
               end
               state_nxt.phase = PH_TRN_END;
            end
            PH_TRN_W: begin
               o_drive              = 1'b0;
               state_nxt.parity_acc = 1'b0;
               state_nxt.bit_count  = '0;
               state_nxt.phase      = PH_WDATA;
            end
            PH_WDATA: begin
               o_out                = state_cur.data_shift[0];
               state_nxt.parity_acc = state_cur.parity_acc ^ state_cur.data_shift[0];
               state_nxt.data_shift = {1'b0, state_cur.data_shift[31:1]};
               if (bc_inc >= DATA_BITS) begin
                  state_nxt.bit_count = '0;
                  state_nxt.phase     = PH_WPAR;
               end else begin
                  state_nxt.bit_count = bc_inc;
               end
            end
            PH_WPAR: begin
               o_out                  = state_cur.parity_acc;
               state_nxt.final_status = ST_OK;
               state_nxt.phase        = PH_IDLE;
               o_done                 = 1'b1;
            end
            PH_TRN_RETRY: begin
               o_drive = 1'b0;
               if (state_cur.attempts_used < ATTEMPTS_SAT) begin
                  state_nxt.attempts_used = state_cur.attempts_used + 8'd1;
               end
               state_nxt.bit_count = '0;
               state_nxt.phase     = PH_REQ;
            end
            PH_TRN_END: begin
               o_drive             = 1'b0;
               state_nxt.bit_count = '0;
               state_nxt.phase     = PH_IDLE;
               o_done              = 1'b1;
            end
            default: begin
               state_nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

   // Result beat fields follow the state after this step.
   assign rsp.swdio_out   = o_out;
   assign rsp.swdio_drive = o_drive;
   assign rsp.clock_pulse = o_clk;
   assign rsp.busy_res    = (state_nxt.phase != PH_IDLE);
   assign rsp.done_res    = o_done;
   assign rsp.status      = state_nxt.final_status;
   assign rsp.read_data   = state_nxt.read_word;

endmodule

@@ rtl/core/swd_host_transaction_engine.sv @@
// Top level of the SWD host transaction engine: state, result register, handshakes.
// Depends on swd_pkg and instantiates swd_step.
//
// Usage: each request beat is either a start (read, write or line reset) or one
// SWCLK tick. A start taken while idle latches APnDP, A[3:2] and the write word;
// a start taken while busy is ignored but still answered. A tick beat carries
// the SWDIO level sampled from the target and returns the level and output
// enable to drive for that clock, plus busy, done, status and the last read word.
// Every request beat yields exactly one response beat.
// Response: registered, and valid in the cycle after the request is accepted.
// Throughput: one beat per cycle unless rsp_ready stalls; the sequencer state updates
// in the same cycle the beat is accepted, so back-to-back ticks need no gap.
// Stall: the response sits in a single output register; req_ready stays high
// while that register is empty or being drained, and drops while rsp_ready is low
// with a pending response, which then stays unchanged.
// Reset: the sequencer returns to idle with all state cleared and the attempt
// limit set to 100; csr_wr_en loads a new limit at the next edge and is meant to
// be used only while no beat is in flight.

module swd_host_transaction_engine #(
   parameter int LINE_RESET_HIGH_CLOCKS = swd_pkg::LINE_RESET_HIGH_CLOCKS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  swd_pkg::swd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output swd_pkg::swd_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);
   import swd_pkg::*;

   swd_state_type state_ff;
   swd_state_type state_in;
   swd_rsp_type   rsp_data_ff;
   swd_rsp_type   rsp_data_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    max_attempts_ff;
   logic [7:0]    max_attempts_in;
   logic          accept;

   // Sequencer logic for one beat.
   swd_step #(
      .LINE_RESET_HIGH_CLOCKS(LINE_RESET_HIGH_CLOCKS)
   ) u_step (
      .state_cur    (state_ff),
      .req          (req_data),
      .max_attempts (max_attempts_ff),
      .state_nxt    (state_in),
      .rsp          (rsp_data_in)
   );

   // Handshake: take a beat whenever the output register is free or draining.
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // Attempt limit register.
   assign max_attempts_in = csr_wr_en ? csr_wr_data : max_attempts_ff;

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         max_attempts_ff <= MAX_ATTEMPTS_RESET;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         max_attempts_ff <= max_attempts_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // Result register; loads only with an accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/swd_checker.sv @@
// Port-level checks for the SWD host transaction engine, bound to its top level.
// Depends on swd_pkg for the beat types.

module swd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input swd_pkg::swd_rsp_type rsp_data
);
   import swd_pkg::*;

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // An empty output register never blocks the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output register");

   // Every accepted request beat is answered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request beat not answered");

   // A finishing tick always leaves the engine idle and carries a clock pulse.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res && rsp_data.clock_pulse)
      else $error("done reported while still busy or without a clock");

   // A released line carries no driven level, and a start beat drives low.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_data.swdio_drive || !rsp_data.clock_pulse) |->
         !rsp_data.swdio_out)
      else $error("level driven on a released or unclocked cycle");

endmodule

bind swd_host_transaction_engine swd_checker u_swd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/tb_swd_host_transaction_engine.sv @@
// Self-checking testbench for swd_host_transaction_engine.
// Depends on swd_pkg and the engine RTL: a scoreboard class predicts every response
// beat, a small target model answers acks and read data, tasks drive the requests.

module tb_swd_host_transaction_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import swd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEM_BUDGET    = 1950;
   localparam int PHASE_COUNT    = 7;

   // Predicts the response of each request beat and checks the responses in order.
   class swd_transfer_scoreboard;
      logic [7:0]  attempt_limit;
      logic [3:0]  phase;
      logic [5:0]  bit_count;
      logic [7:0]  header;
      logic [31:0] data_shift;
      logic [2:0]  ack_shift;
      logic        parity_acc;
      logic [7:0]  attempts_used;
      logic        is_write;
      logic [31:0] read_word;
      logic [2:0]  final_status;
      swd_rsp_type expected_beats[$];
      int unsigned errors;

      function new();
         attempt_limit = MAX_ATTEMPTS_RESET;
         phase         = PH_IDLE;
         bit_count     = '0;
         header        = '0;
         data_shift    = '0;
         ack_shift     = '0;
         parity_acc    = 1'b0;
         attempts_used = '0;
         is_write      = 1'b0;
         read_word     = '0;
         final_status  = ST_OK;
         errors        = 0;
      endfunction

      function void set_attempt_limit(logic [7:0] value);
         attempt_limit = value;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // Advance the sequencer by one accepted request beat and queue its response.
      function void note_request(swd_req_type r);
         swd_rsp_type e;
         logic [7:0]  limit;
         logic        rnw;
         e = '0;
         e.swdio_drive = 1'b1;
         limit = (attempt_limit == 8'd0) ? 8'd1 : attempt_limit;
         if (r.action != ACT_TICK) begin
            // Starts only take effect while idle.
            if (phase == PH_IDLE) begin
               final_status = ST_OK;
               bit_count = '0;
               if (r.action == ACT_LINE_RESET) begin
                  phase = PH_LRESET;
               end else begin
                  is_write = (r.action == ACT_WRITE);
                  rnw = ~is_write;
                  header = 8'b1000_0001;
                  header[1] = r.port_is_ap;
                  header[2] = rnw;
                  header[4:3] = r.reg_addr;
                  header[5] = r.port_is_ap ^ rnw ^ r.reg_addr[0] ^ r.reg_addr[1];
                  data_shift = r.write_data;
                  attempts_used = 8'd1;
                  phase = PH_REQ;
               end
            end
         end else begin
            e.clock_pulse = 1'b1;
            case (phase)
               PH_LRESET: begin
                  if (int'(bit_count) < LINE_RESET_HIGH_CLOCKS_DEFAULT) begin
                     e.swdio_out = 1'b1;
                     bit_count = bit_count + 6'd1;
                  end else begin
                     bit_count = '0;
                     final_status = ST_OK;
                     phase = PH_IDLE;
                     e.done_res = 1'b1;
                  end
               end
               PH_REQ: begin
                  e.swdio_out = header[bit_count[2:0]];
                  bit_count = bit_count + 6'd1;
                  if (bit_count >= REQ_BITS) begin
                     bit_count = '0;
                     phase = PH_TRN_ACK;
                  end
               end
               PH_TRN_ACK: begin
                  e.swdio_drive = 1'b0;
                  ack_shift = '0;
                  bit_count = '0;
                  phase = PH_ACK;
               end
               PH_ACK: begin
                  e.swdio_drive = 1'b0;
                  ack_shift[bit_count[1:0]] = r.swdio_in;
                  bit_count = bit_count + 6'd1;
                  if (bit_count >= ACK_BITS) begin
                     bit_count = '0;
                     if (ack_shift == ACK_OK) begin
                        if (is_write) begin
                           phase = PH_TRN_W;
                        end else begin
                           data_shift = '0;
                           parity_acc = 1'b0;
                           phase = PH_RDATA;
                        end
                     end else if (ack_shift == ACK_WAIT) begin
                        if (attempts_used < limit) begin
                           phase = PH_TRN_RETRY;
                        end else begin
                           final_status = ST_WAIT_LIMIT;
                           phase = PH_TRN_END;
                        end
                     end else if (ack_shift == ACK_FAULT) begin
                        final_status = ST_FAULT;
                        phase = PH_TRN_END;
                     end else begin
                        final_status = ST_BAD_ACK;
                        phase = PH_TRN_END;
                     end
                  end
               end
               PH_RDATA: begin
                  e.swdio_drive = 1'b0;
                  data_shift = {r.swdio_in, data_shift[31:1]};
                  parity_acc ^= r.swdio_in;
                  bit_count = bit_count + 6'd1;
                  if (bit_count >= DATA_BITS) begin
                     bit_count = '0;
                     phase = PH_RPAR;
                  end
               end
               PH_RPAR: begin
                  e.swdio_drive = 1'b0;
                  // A bad parity bit keeps the previous read word.
                  if (r.swdio_in == parity_acc) begin
                     read_word = data_shift;
                     final_status = ST_OK;
                  end else begin
                     final_status = ST_PARITY_ERR;
                  end
                  phase = PH_TRN_END;
               end
               PH_TRN_W: begin
                  e.swdio_drive = 1'b0;
                  parity_acc = 1'b0;
                  bit_count = '0;
                  phase = PH_WDATA;
               end
               PH_WDATA: begin
                  e.swdio_out = data_shift[0];
                  parity_acc ^= data_shift[0];
                  data_shift = data_shift >> 1;
                  bit_count = bit_count + 6'd1;
                  if (bit_count >= DATA_BITS) begin
                     bit_count = '0;
                     phase = PH_WPAR;
                  end
               end
               PH_WPAR: begin
                  e.swdio_out = parity_acc;
                  final_status = ST_OK;
                  phase = PH_IDLE;
                  e.done_res = 1'b1;
               end
               PH_TRN_RETRY: begin
                  e.swdio_drive = 1'b0;
                  if (attempts_used < ATTEMPTS_SAT) attempts_used = attempts_used + 8'd1;
                  bit_count = '0;
                  phase = PH_REQ;
               end
               PH_TRN_END: begin
                  e.swdio_drive = 1'b0;
                  bit_count = '0;
                  phase = PH_IDLE;
                  e.done_res = 1'b1;
               end
               default: begin
                  // Idle ticks drive the line low.
                  phase = PH_IDLE;
               end
            endcase
         end
         e.busy_res = (phase != PH_IDLE);
         e.status = final_status;
         e.read_data = read_word;
         expected_beats.push_back(e);
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
                  got, want);
      endtask

      // Compare one accepted response beat with the oldest prediction.
      task check_response(swd_rsp_type got);
         swd_rsp_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected response beat", 32'(got.status), 32'd0);
         end else begin
            want = expected_beats.pop_front();
            if (got.swdio_out !== want.swdio_out)
               report_mismatch("swdio_out", 32'(got.swdio_out), 32'(want.swdio_out));
            if (got.swdio_drive !== want.swdio_drive)
               report_mismatch("swdio_drive", 32'(got.swdio_drive),
                               32'(want.swdio_drive));
            if (got.clock_pulse !== want.clock_pulse)
               report_mismatch("clock_pulse", 32'(got.clock_pulse),
                               32'(want.clock_pulse));
            if (got.busy_res !== want.busy_res)
               report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            if (got.done_res !== want.done_res)
               report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.read_data !== want.read_data)
               report_mismatch("read_data", got.read_data, want.read_data);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   swd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   swd_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   swd_transfer_scoreboard sb = new();

   // Target model: planned acks per attempt, the word to return and a parity flip.
   logic [2:0]  ack_plan[$];
   logic [31:0] read_plan;
   logic        bad_parity;

   int  beats_sent = 0;
   int  stray_pct = 2;
   int  quiet_cycles = 0;
   int  rsp_hold_cycles = 0;
   logic tx_steady = 1'b0;
   logic rx_steady = 1'b0;

   swd_host_transaction_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Monitor: check responses, feed accepted requests and writes to the scoreboard.
   always @(posedge clock) begin
      logic moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_wr_en) sb.set_attempt_limit(csr_wr_data);
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_data);
            moved = 1'b1;
         end
         if (req_valid && req_ready) begin
            sb.note_request(req_data);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Response side: random stalls, mostly short, and long hold-offs on request.
   initial begin : rsp_side
      int stall_left;
      int r;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall_left == 0 && !rx_steady) begin
            r = $urandom_range(0, 99);
            if (r >= 70) stall_left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 25);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_steady || r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // Level the target puts on SWDIO for the next tick, from the predicted phase.
   function automatic logic target_level();
      logic level;
      level = 1'($urandom_range(0, 1));
      case (sb.phase)
         PH_ACK: begin
            if (ack_plan.size() != 0) begin
               level = ack_plan[0][sb.bit_count[1:0]];
               if (sb.bit_count == 6'd2) void'(ack_plan.pop_front());
            end
         end
         PH_RDATA: level = read_plan[sb.bit_count[4:0]];
         PH_RPAR:  level = (^read_plan) ^ bad_parity;
         default:  level = level;
      endcase
      return level;
   endfunction

   // Offer one request beat after a random gap and return at the falling edge after it
   // is taken; the caller drives the next beat or lowers valid at that same edge.
   task automatic issue(input logic [1:0] act, input logic ap, input logic [1:0] addr,
                        input logic [31:0] wdata);
      int          gap;
      swd_req_type b;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      b.action = act;
      b.port_is_ap = ap;
      b.reg_addr = addr;
      b.write_data = wdata;
      b.swdio_in = (act == ACT_TICK) ? target_level() : 1'($urandom_range(0, 1));
      req_data <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic tick();
      issue(ACT_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom());
   endtask

   // Start a transaction or line reset and tick it to the end, with stray starts.
   task automatic run_txn(input logic [1:0] act, input logic ap, input logic [1:0] addr,
                          input logic [31:0] wdata);
      issue(act, ap, addr, wdata);
      while (sb.phase != PH_IDLE) begin
         if ($urandom_range(0, 99) < stray_pct)
            issue(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), $urandom());
         else
            tick();
      end
   endtask

   // Hold the request side until every predicted response has been seen.
   task automatic pause_sender();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      pause_sender();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [2:0] invalid_ack();
      logic [2:0] a;
      do a = 3'($urandom_range(0, 7));
      while (a == ACK_OK || a == ACK_WAIT || a == ACK_FAULT);
      return a;
   endfunction

   // One random transaction, line reset or idle tick.
   task automatic random_txn();
      int kind;
      int s;
      int nwait;
      int w;
      kind = $urandom_range(0, 99);
      ack_plan.delete();
      bad_parity = ($urandom_range(0, 9) == 0);
      w = $urandom_range(0, 9);
      read_plan = (w == 0) ? 32'h0 : (w == 1) ? 32'hFFFF_FFFF : $urandom();
      if (kind < 7) begin
         run_txn(ACT_LINE_RESET, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 $urandom());
      end else if (kind < 11) begin
         tick();
      end else begin
         s = $urandom_range(0, 99);
         nwait = (s >= 60 && s < 72) ? $urandom_range(3, 6) : $urandom_range(0, 2);
         repeat (nwait) ack_plan.push_back(ACK_WAIT);
         if (s < 72) ack_plan.push_back(ACK_OK);
         else if (s < 82) ack_plan.push_back(ACK_FAULT);
         else if (s < 92) ack_plan.push_back(invalid_ack());
         // Otherwise the ack bits are random noise.
         run_txn((kind < 55) ? ACT_READ : ACT_WRITE, 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 3)), $urandom());
      end
   endtask

   initial begin : main
      logic [7:0] limits[PHASE_COUNT];
      int quota;
      logic hold_done;
      limits = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd100, 8'd3, 8'd0};
      limits[6] = 8'($urandom_range(4, 254));
      bad_parity = 1'b0;
      read_plan = '0;
      hold_done = 1'b0;

      // Synchronous reset.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: idle tick, clean read and write at the field extremes.
      tick();
      ack_plan = '{ACK_OK};
      read_plan = 32'h0;
      run_txn(ACT_READ, 1'b0, 2'd0, 32'h0);
      ack_plan = '{ACK_OK};
      run_txn(ACT_WRITE, 1'b1, 2'd3, 32'hFFFF_FFFF);
      ack_plan = '{ACK_OK};
      read_plan = 32'hFFFF_FFFF;
      run_txn(ACT_READ, 1'b1, 2'd3, 32'h0);
      // Two WAIT answers and then OK, with frequent ignored starts while busy.
      stray_pct = 20;
      ack_plan = '{ACK_WAIT, ACK_WAIT, ACK_OK};
      read_plan = 32'hA5C3_0F96;
      run_txn(ACT_READ, 1'b0, 2'd2, 32'h1234_5678);
      stray_pct = 2;
      // FAULT, invalid acks and a read with a bad parity bit.
      ack_plan = '{ACK_FAULT};
      run_txn(ACT_WRITE, 1'b0, 2'd1, 32'h0);
      ack_plan = '{3'b000};
      run_txn(ACT_READ, 1'b1, 2'd1, 32'h0);
      ack_plan = '{3'b111};
      run_txn(ACT_WRITE, 1'b1, 2'd2, 32'h8000_0001);
      ack_plan = '{ACK_OK};
      read_plan = 32'h0000_0001;
      bad_parity = 1'b1;
      run_txn(ACT_READ, 1'b0, 2'd3, 32'h0);
      bad_parity = 1'b0;
      run_txn(ACT_LINE_RESET, 1'b0, 2'd0, 32'h0);
      // Attempt limit of one, then zero, which behaves like one.
      write_limit(8'd1);
      ack_plan = '{ACK_WAIT};
      run_txn(ACT_READ, 1'b1, 2'd0, 32'h0);
      write_limit(8'd0);
      ack_plan = '{ACK_WAIT, ACK_WAIT};
      run_txn(ACT_WRITE, 1'b0, 2'd0, 32'h0);

      // Random phases, one per attempt limit setting.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_limit(limits[p]);
         tx_steady = (p == 4);
         rx_steady = (p == 4) || (p == 6);
         quota = beats_sent + (ITEM_BUDGET - beats_sent) / (PHASE_COUNT - p);
         while (beats_sent < quota) begin
            // Long response hold-off while requests keep coming.
            if (p == 2 && !hold_done) begin
               rsp_hold_cycles = 60;
               hold_done = 1'b1;
            end
            random_txn();
         end
      end

      pause_sender();
      repeat (8) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/swd_pkg.sv
rtl/core/swd_step.sv
rtl/core/swd_host_transaction_engine.sv
rtl/core/swd_checker.sv
tb/sv/tb_swd_host_transaction_engine.sv
